// File: hw/rtl/bas_pkg.sv
// ----------------------------------------------------------------------------
// bas_pkg
// Types and constants shared by the bump allocator core and its channels.
// ----------------------------------------------------------------------------
package bas_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_ALIGN = 2'd2,
		ST_OOM   = 2'd3
	} status_t;

	// Request modes.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// Sizes are rounded up to this granule (a power of two).
	localparam logic [16:0] SIZE_GRAIN = 17'd4;

	// Pool size after reset.
	localparam logic [15:0] POOL_SIZE_RESET = 16'd4096;

	typedef struct packed {
		logic        mode;
		logic [15:0] req_size;
		logic [15:0] alignment;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] offset;
		logic [15:0] used_bytes;
		logic [15:0] free_bytes;
		logic [15:0] alloc_count;
		logic [15:0] peak_used;
		logic [15:0] largest_alloc;
		logic [15:0] smallest_alloc;
	} rsp_t;

	typedef logic [15:0] cfg_t;

endpackage

// File: hw/rtl/bas_stream_if.sv
// ----------------------------------------------------------------------------
// bas_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bas_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/bump_allocator_with_stats_core.sv
// ----------------------------------------------------------------------------
// bump_allocator_with_stats_core
// Bump-pointer arena allocator that also keeps usage statistics.
// A request transaction is offered as a result once it has passed from the
// input register into the result register.
// Throughput: one request per cycle while the result side is ready; a stall
// on rsp.ready holds the pipeline. The offset update between them is combinational.
// Reset: arst_n clears the offset, the statistics and both valid flags, and
// loads the pool size register with 4096.
// ----------------------------------------------------------------------------
module bump_allocator_with_stats_core
	import bas_pkg::*;
#(
	parameter int unsigned POOL_ADDR_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	bas_stream_if.sink   cfg,
	bas_stream_if.sink   req,
	bas_stream_if.source rsp
);

	localparam int unsigned AW = POOL_ADDR_BITS;

	// Largest offset that fits in AW bits; it caps the usable pool size.
	localparam logic [15:0] ADDR_CAP = 16'((1 << AW) - 1);

	// Configuration register. The user must write it only while the core is
	// idle; the core itself does not enforce this. The port is always ready.
	cfg_t pool_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= POOL_SIZE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			pool_size_q <= cfg.data;
		end
	end

	assign cfg.ready = 1'b1;

	// Allocator state. Every granted offset, size and end point stays at or
	// below the usable limit, so AW bits hold them all.
	logic [AW-1:0] bump_q;
	logic [15:0]   alloc_total_q;
	logic [AW-1:0] peak_q;
	logic [AW-1:0] largest_q;
	logic [AW-1:0] smallest_q;

	// Pipeline: the input register (stage 1) holds an accepted request; the
	// result register (stage 2) holds the finished result until it is taken.
	// Stage 1 moves on whenever stage 2 is empty or being drained, and the
	// state is updated in that same cycle, so the next request in stage 1
	// already sees it.
	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_s2;
	logic valid_s2;
	logic advance;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Usable limit: the configured pool size, capped by the offset width.
	logic [AW-1:0] limit;
	assign limit = (pool_size_q < ADDR_CAP) ? pool_size_q[AW-1:0] : ADDR_CAP[AW-1:0];

	// Request arithmetic, all formed wide enough that nothing wraps.
	logic [16:0] size_w;
	logic [16:0] align_w;
	logic [16:0] rsize;
	logic [16:0] start_w;
	logic [17:0] end_w;
	logic        align_ok;
	logic        fits;

	assign size_w   = {1'b0, req_s1.req_size};
	assign align_w  = {1'b0, req_s1.alignment};
	// A nonzero size rounded up to the granule is always at least one granule.
	assign rsize    = (size_w + SIZE_GRAIN - 17'd1) & ~(SIZE_GRAIN - 17'd1);
	assign align_ok = (req_s1.alignment != 16'd0) &&
	                  ((req_s1.alignment & (req_s1.alignment - 16'd1)) == 16'd0);
	assign start_w  = (17'(bump_q) + align_w - 17'd1) & ~(align_w - 17'd1);
	assign end_w    = {1'b0, start_w} + {1'b0, rsize};
	assign fits     = end_w <= 18'(limit);

	// Next state and result status.
	status_t       status;
	logic [AW-1:0] granted;
	logic [AW-1:0] bump_d;
	logic [15:0]   alloc_total_d;
	logic [AW-1:0] peak_d;
	logic [AW-1:0] largest_d;
	logic [AW-1:0] smallest_d;
	logic [AW-1:0] rsize_a;
	logic [AW-1:0] end_a;
	logic [AW-1:0] free_d;

	// Truncation is safe where used: on a grant both values are at most limit.
	assign rsize_a = rsize[AW-1:0];
	assign end_a   = end_w[AW-1:0];

	always_comb begin
		status        = ST_OK;
		granted       = '0;
		bump_d        = bump_q;
		alloc_total_d = alloc_total_q;
		peak_d        = peak_q;
		largest_d     = largest_q;
		smallest_d    = smallest_q;
		if (req_s1.mode == MODE_CLEAR) begin
			bump_d        = '0;
			alloc_total_d = '0;
			peak_d        = '0;
			largest_d     = '0;
			smallest_d    = '0;
		end else if (req_s1.req_size == 16'd0) begin
			status = ST_ZERO;
		end else if (!align_ok) begin
			status = ST_ALIGN;
		end else if (!fits) begin
			status = ST_OOM;
		end else begin
			granted = start_w[AW-1:0];
			bump_d  = end_a;
			if (end_a > peak_q) begin
				peak_d = end_a;
			end
			if (rsize_a > largest_q) begin
				largest_d = rsize_a;
			end
			// The first grant after a clear always sets the smallest size.
			if (alloc_total_q == 16'd0 || rsize_a < smallest_q) begin
				smallest_d = rsize_a;
			end
			if (alloc_total_q != 16'hFFFF) begin
				alloc_total_d = alloc_total_q + 16'd1;
			end
		end
	end

	// Free space never goes negative, even after the pool was shrunk below use.
	assign free_d = (limit > bump_d) ? (limit - bump_d) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			bump_q        <= '0;
			alloc_total_q <= '0;
			peak_q        <= '0;
			largest_q     <= '0;
			smallest_q    <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2      <= 1'b1;
				bump_q        <= bump_d;
				alloc_total_q <= alloc_total_d;
				peak_q        <= peak_d;
				largest_q     <= largest_d;
				smallest_q    <= smallest_d;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset; their valid flags guard them.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (advance) begin
			rsp_s2.status         <= status;
			rsp_s2.offset         <= 16'(granted);
			rsp_s2.used_bytes     <= 16'(bump_d);
			rsp_s2.free_bytes     <= 16'(free_d);
			rsp_s2.alloc_count    <= alloc_total_d;
			rsp_s2.peak_used      <= 16'(peak_d);
			rsp_s2.largest_alloc  <= 16'(largest_d);
			rsp_s2.smallest_alloc <= 16'(smallest_d);
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

`ifndef SYNTHESIS
	// With no result pending the core must always take a new request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> req.ready)
		else $error("request stalled with an empty result register");

	// A granted block never starts beyond the resulting offset.
	a_offset_below_used: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (rsp_s2.offset <= rsp_s2.used_bytes))
		else $error("granted offset lies beyond the bump offset");

	// The peak can never trail the current use.
	a_peak_covers_used: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (rsp_s2.peak_used >= rsp_s2.used_bytes))
		else $error("peak use below current use");

	// The smallest recorded size never exceeds the largest.
	a_smallest_le_largest: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (rsp_s2.smallest_alloc <= rsp_s2.largest_alloc))
		else $error("smallest allocation above largest allocation");
`endif

endmodule

// File: sim/bump_allocator_with_stats_core_tb.sv
// ----------------------------------------------------------------------------
// bump_allocator_with_stats_core_tb
// Self-checking bench for the bump allocator core. Drives allocate and clear
// requests over the request channel and changes the pool size between
// phases. An in-bench allocator model predicts every result transaction, and
// each one is checked field by field as it leaves the core.
// ----------------------------------------------------------------------------
module bump_allocator_with_stats_core_tb;
	import bas_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_BITS   = 16;
	localparam int CYCLE_LIMIT = 1000000;
	// The core offers a result once a request has passed from its input register
	// into its result register, so the SETTLE wait lets it settle once nothing is pending.
	localparam int SETTLE      = 6;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bas_stream_if #(.payload_t(cfg_t)) cfg_if ();
	bas_stream_if #(.payload_t(req_t)) req_if ();
	bas_stream_if #(.payload_t(rsp_t)) rsp_if ();

	bump_allocator_with_stats_core #(
		.POOL_ADDR_BITS(ADDR_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_if),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// ------------------------------------------------------------------
	// Allocator model. It mirrors the core's architectural state and is
	// advanced once per accepted request, in acceptance order. All sums are
	// formed at 32 bits so that aligned starts and rounded sizes past 16 bits
	// show up as out of memory instead of wrapping.
	// ------------------------------------------------------------------
	logic [31:0] pool_bytes;
	logic [31:0] bump_pos;
	logic [31:0] grant_count;
	logic [31:0] high_water;
	logic [31:0] biggest_grant;
	logic [31:0] tiniest_grant;

	rsp_t expected_rsp_q[$];

	function automatic rsp_t predict_alloc(input req_t r);
		rsp_t        o;
		logic [31:0] limit;
		logic [31:0] sz;
		logic [31:0] al;
		logic [31:0] rsize;
		logic [31:0] start;
		logic [31:0] stop;
		limit = ((32'd1 << ADDR_BITS) - 1 < pool_bytes) ? (32'd1 << ADDR_BITS) - 1
			: pool_bytes;
		sz = {16'd0, r.req_size};
		al = {16'd0, r.alignment};
		o = '0;
		o.status = ST_OK;
		if (r.mode == MODE_CLEAR) begin
			bump_pos = 0;
			grant_count = 0;
			high_water = 0;
			biggest_grant = 0;
			tiniest_grant = 0;
		end else if (sz == 0) begin
			o.status = ST_ZERO;
		end else if (al == 0 || (al & (al - 1)) != 0) begin
			o.status = ST_ALIGN;
		end else begin
			// Round up to the 4-byte granule; a size of 1 to 3 becomes 4.
			rsize = (sz + 32'd3) & ~32'd3;
			if (rsize < 32'd4)
				rsize = 32'd4;
			start = (bump_pos + al - 1) & ~(al - 1);
			stop = start + rsize;
			if (stop > limit) begin
				o.status = ST_OOM;
			end else begin
				o.offset = start[15:0];
				bump_pos = stop;
				if (bump_pos > high_water)
					high_water = bump_pos;
				if (rsize > biggest_grant)
					biggest_grant = rsize;
				if (grant_count == 0 || rsize < tiniest_grant)
					tiniest_grant = rsize;
				if (grant_count < 32'hFFFF)
					grant_count = grant_count + 1;
			end
		end
		o.used_bytes = bump_pos[15:0];
		o.free_bytes = (limit > bump_pos) ? 16'(limit - bump_pos) : 16'd0;
		o.alloc_count = grant_count[15:0];
		o.peak_used = high_water[15:0];
		o.largest_alloc = biggest_grant[15:0];
		o.smallest_alloc = tiniest_grant[15:0];
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Bookkeeping shared by the checker, the timeout and the summary.
	// ------------------------------------------------------------------
	int n_errors    = 0;
	int n_cycles    = 0;
	int n_requests  = 0;
	int n_results   = 0;
	int n_pool_sets = 0;
	int n_by_status[4];
	rsp_t want_rsp;

	task automatic report_fail(input string msg);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got)
			report_fail($sformatf("result %0d field %s: expected %0d, got %0d",
				n_results, name, want, got));
	endtask

	// The timeout guards against a hung handshake anywhere in the run.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("ERROR: cycle limit of %0d reached", CYCLE_LIMIT);
			$display("bump_allocator_with_stats_core_tb failed");
			$finish;
		end
	end

	// Result checker. A result transaction completes at an edge where valid
	// and ready were both high; values are read in the active region of that
	// edge, before any nonblocking update lands.
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_rsp_q.size() == 0) begin
				report_fail("result transaction with no request outstanding");
			end else begin
				want_rsp = expected_rsp_q.pop_front();
				check_field("status", want_rsp.status, rsp_if.data.status);
				check_field("offset", want_rsp.offset, rsp_if.data.offset);
				check_field("used_bytes", want_rsp.used_bytes, rsp_if.data.used_bytes);
				check_field("free_bytes", want_rsp.free_bytes, rsp_if.data.free_bytes);
				check_field("alloc_count", want_rsp.alloc_count,
					rsp_if.data.alloc_count);
				check_field("peak_used", want_rsp.peak_used, rsp_if.data.peak_used);
				check_field("largest_alloc", want_rsp.largest_alloc,
					rsp_if.data.largest_alloc);
				check_field("smallest_alloc", want_rsp.smallest_alloc,
					rsp_if.data.smallest_alloc);
				n_by_status[want_rsp.status]++;
			end
			n_results++;
		end
	end

	// ------------------------------------------------------------------
	// Result-side flow control. Ready drops at random: mostly single cycles or
	// short bursts, now and then a long stall. A test can also ask for one
	// long hold-off; the request is passed by a sequence number so that only
	// this process ever writes ready or its own countdown.
	// ------------------------------------------------------------------
	logic rsp_idle_on;
	int   hold_len_req;
	int   hold_req_seq;
	int   hold_ack_seq;
	int   stall_left;

	initial begin
		rsp_if.ready <= 1'b0;
		hold_ack_seq = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req_seq != hold_ack_seq) begin
				hold_ack_seq = hold_req_seq;
				stall_left = hold_len_req;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if (!rsp_idle_on || $urandom_range(0, 99) < 75) begin
				rsp_if.ready <= 1'b1;
			end else begin
				stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
					: $urandom_range(10, 40);
				rsp_if.ready <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side.
	// ------------------------------------------------------------------

	// Idle cycles after a request: mostly none or a few, sometimes a long gap.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Offers one request and returns at the edge where it was accepted (or
	// after the gap that follows). Valid stays high when no gap follows, so
	// back-to-back requests never lower and raise it in the same time step.
	task automatic send_req(input req_t r, input int gap);
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do
			@(posedge clk);
		while (!req_if.ready);
		expected_rsp_q.push_back(predict_alloc(r));
		n_requests++;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue(input logic mode, input logic [15:0] req_size,
			input logic [15:0] alignment);
		req_t r;
		r.mode = mode;
		r.req_size = req_size;
		r.alignment = alignment;
		send_req(r, pick_gap());
	endtask

	// Stops offering requests and waits until every predicted result has
	// come back, then lets the pipeline settle.
	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// The pool size is only rewritten once the core has nothing in flight.
	task automatic write_pool(input cfg_t bytes);
		drain_results();
		cfg_if.valid <= 1'b1;
		cfg_if.data <= bytes;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		pool_bytes = {16'd0, bytes};
		n_pool_sets++;
	endtask

	// Random request mix. Most requests are well-formed allocations with
	// small sizes and modest alignments so the arena actually fills; the
	// rest are clears, zero sizes, broken alignments and oversized asks.
	function automatic req_t make_req();
		req_t r;
		int   pick;
		r.mode = MODE_ALLOC;
		r.req_size = 16'($urandom_range(1, 64));
		r.alignment = 16'd1 << $urandom_range(0, 6);
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			r.mode = MODE_CLEAR;
			r.req_size = 16'($urandom());
			r.alignment = 16'($urandom());
		end else if (pick < 6) begin
			r.req_size = 16'd0;
			r.alignment = 16'($urandom());
		end else if (pick < 10) begin
			r.req_size = 16'($urandom());
			r.alignment = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
		end else if (pick < 14) begin
			r.req_size = 16'($urandom());
			r.alignment = 16'd1 << $urandom_range(0, 15);
		end else begin
			if ($urandom_range(0, 9) >= 7)
				r.req_size = ($urandom_range(0, 2) < 2) ? 16'($urandom_range(65, 1024))
					: 16'($urandom_range(1025, 16384));
			if ($urandom_range(0, 9) >= 8)
				r.alignment = 16'd1 << $urandom_range(7, 15);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Error ordering at the reset pool size: a zero size wins over a bad
	// alignment, which wins over a size that could never fit. A clear takes
	// no notice of its size and alignment fields.
	task automatic test_error_priority();
		issue(MODE_CLEAR, 16'hFFFF, 16'h0003);
		issue(MODE_ALLOC, 16'd0, 16'h0003);
		issue(MODE_ALLOC, 16'd0, 16'd0);
		issue(MODE_ALLOC, 16'hFFFF, 16'd0);
		issue(MODE_ALLOC, 16'd8, 16'h8001);
		issue(MODE_ALLOC, 16'd8, 16'hFFFF);
	endtask

	// Rounding to the granule, the first grant setting the smallest size,
	// padding up to an alignment, and rounding that carries past 16 bits.
	task automatic test_rounding_alignment();
		issue(MODE_ALLOC, 16'd1, 16'd1);
		issue(MODE_ALLOC, 16'd5, 16'd1);
		issue(MODE_ALLOC, 16'd3, 16'd16);
		issue(MODE_ALLOC, 16'hFFFF, 16'd1);
		issue(MODE_ALLOC, 16'd8, 16'h8000);
	endtask

	// The largest pool and the smallest that can hold a grant: one filled to within three bytes,
	// one filled exactly, each followed by a request that no longer fits.
	task automatic test_pool_extremes();
		write_pool(16'hFFFF);
		issue(MODE_CLEAR, 16'd0, 16'd0);
		issue(MODE_ALLOC, 16'hFFFC, 16'd1);
		issue(MODE_ALLOC, 16'd1, 16'd2);
		write_pool(16'd4);
		issue(MODE_CLEAR, 16'd0, 16'd0);
		issue(MODE_ALLOC, 16'd4, 16'd4);
		issue(MODE_ALLOC, 16'd1, 16'd1);
	endtask

	// Shrinking the pool under live allocations leaves no free space, and
	// pool sizes under the granule are taken as written.
	task automatic test_pool_shrink();
		write_pool(16'd4096);
		issue(MODE_CLEAR, 16'd0, 16'd0);
		issue(MODE_ALLOC, 16'd100, 16'd4);
		write_pool(16'd40);
		issue(MODE_ALLOC, 16'd1, 16'd1);
		write_pool(16'd0);
		issue(MODE_ALLOC, 16'd1, 16'd1);
		issue(MODE_CLEAR, 16'd0, 16'd0);
		write_pool(16'd3);
		issue(MODE_ALLOC, 16'd1, 16'd1);
	endtask

	// Holds the result side off for a long stretch while requests keep
	// coming back to back, so the core fills and pushes back on its input.
	// The sender then waits for every outstanding result.
	task automatic test_backpressure();
		write_pool(16'd8192);
		hold_len_req <= 300;
		hold_req_seq <= hold_req_seq + 1;
		for (int i = 0; i < 40; i++)
			send_req(make_req(), 0);
		drain_results();
	endtask

	// Random phases, each with its own pool size. One phase runs with no
	// idling on either side to keep the core at full rate.
	task automatic test_random(input int per_phase);
		cfg_t pools[8];
		pools[0] = 16'd4;
		pools[1] = 16'hFFFF;
		pools[2] = 16'd4096;
		pools[3] = 16'($urandom_range(4, 255));
		pools[4] = 16'($urandom());
		pools[5] = 16'($urandom_range(256, 8191));
		pools[6] = 16'($urandom_range(0, 3));
		pools[7] = 16'd1024;
		for (int ph = 0; ph < 8; ph++) begin
			write_pool(pools[ph]);
			rsp_idle_on <= (ph != 2);
			if ($urandom_range(0, 1) == 1)
				issue(MODE_CLEAR, 16'($urandom()), 16'($urandom()));
			for (int i = 0; i < per_phase; i++)
				send_req(make_req(), (ph == 2) ? 0 : pick_gap());
			drain_results();
		end
		rsp_idle_on <= 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		// The model starts from the core's reset state.
		pool_bytes = {16'd0, POOL_SIZE_RESET};
		bump_pos = 0;
		grant_count = 0;
		high_water = 0;
		biggest_grant = 0;
		tiniest_grant = 0;
		n_by_status = '{default: 0};
		hold_len_req <= 0;
		hold_req_seq <= 0;
		rsp_idle_on <= 1'b1;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_error_priority();
		test_rounding_alignment();
		test_pool_extremes();
		test_pool_shrink();
		test_backpressure();
		test_random(250);

		drain_results();
		if (expected_rsp_q.size() != 0)
			report_fail($sformatf("%0d results never arrived", expected_rsp_q.size()));

		$display("Covered %0d requests and %0d results over %0d pool sizes.",
			n_requests, n_results, n_pool_sets);
		$display("Outcomes: %0d ok, %0d zero size, %0d bad align, %0d no room; %0d mismatches.",
			n_by_status[ST_OK], n_by_status[ST_ZERO], n_by_status[ST_ALIGN],
			n_by_status[ST_OOM], n_errors);
		if (n_errors == 0)
			$display("bump_allocator_with_stats_core_tb passed");
		else
			$display("bump_allocator_with_stats_core_tb failed");
		$finish;
	end

endmodule
